// ----- hw/rtl/conv3x3_decimate_by_two_assert.svh -----
// Assertion macros used by the conv3x3_decimate_by_two module.
`ifndef CONV3X3_DECIMATE_BY_TWO_ASSERT_SVH
`define CONV3X3_DECIMATE_BY_TWO_ASSERT_SVH
// Check that a condition implies another at the same edge.
`define C3D_ASSERT_IMPL(lbl, clk_s, rst_n, a, b) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |-> (b)) \
		else $error("c3d implication failed");
// Check that a condition implies another at the next edge.
`define C3D_ASSERT_NEXT(lbl, clk_s, rst_n, a, b) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (a) |=> (b)) \
		else $error("c3d next-cycle check failed");
`endif

// ----- hw/rtl/c3d_pkg.sv -----
package c3d_pkg;
	localparam int unsigned PIX_W = 8;
	localparam int unsigned COEF_BITS = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;
	localparam logic [1:0] MODE_WRAP = 2'd0;
	localparam logic [1:0] MODE_ABS = 2'd1;
	localparam logic [1:0] MODE_CLAMP = 2'd2;
	// undefined mode, behaves as clamp
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int unsigned SUM_W = 24;
	localparam int unsigned DIV_STEPS = SUM_W;

	// Controller to datapath commands
	typedef struct packed {
		logic load;     // take pixel, update line stores and window
		logic win_vld;  // window complete: latch sum inputs
		logic mac_step; // accumulate one tap
		logic mac_clr;
		logic div_start;
		logic div_step;
		logic finish;   // form output pixel into output register
	} c3d_cmd_t;

	typedef struct packed {
		logic div_need;
	} c3d_sts_t;
endpackage

// ----- hw/rtl/c3d_ram.sv -----
module c3d_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read-before-write single port
	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ----- hw/rtl/c3d_datapath.sv -----
module c3d_datapath #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  c3d_pkg::c3d_cmd_t                 cmd,
	output c3d_pkg::c3d_sts_t                 sts,
	input  logic [c3d_pkg::PIX_W-1:0]         pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]      col_addr,
	input  logic [3:0]                        tap,
	input  logic [3*c3d_pkg::COEF_BITS-1:0]   coef_top,
	input  logic [3*c3d_pkg::COEF_BITS-1:0]   coef_mid,
	input  logic [3*c3d_pkg::COEF_BITS-1:0]   coef_bot,
	input  logic [7:0]                        divisor,
	input  logic [1:0]                        out_mode,
	output logic [7:0]                        res_pix
);
	localparam int unsigned SW = c3d_pkg::SUM_W;
	localparam int unsigned CB = c3d_pkg::COEF_BITS;

	logic [7:0] top_rd, mid_rd;
	logic [7:0] wcol_q [6];
	logic [7:0] p_q [9];
	logic signed [SW-1:0] acc_q;
	logic [SW-1:0] quo_q, rem_q;
	logic neg_q;
	logic signed [CB-1:0] cf;
	logic [3*CB-1:0] crow;
	logic [1:0] tk;
	logic signed [CB+9:0] prod;
	logic [SW:0] rem_sh;
	logic signed [SW:0] sval;

	c3d_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
		.clk(clk), .we(cmd.load), .addr(col_addr), .wdata(mid_rd), .rdata(top_rd));
	c3d_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
		.clk(clk), .we(cmd.load), .addr(col_addr), .wdata(pixel), .rdata(mid_rd));

	// Line store read data is registered and ready in the cycle after the address; the
	// controller issues load in that cycle.
	// Latch the window and shift the column registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) wcol_q[i] <= '0;
		end else if (cmd.load) begin
			wcol_q[0] <= wcol_q[1]; wcol_q[1] <= top_rd;
			wcol_q[2] <= wcol_q[3]; wcol_q[3] <= mid_rd;
			wcol_q[4] <= wcol_q[5]; wcol_q[5] <= pixel;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.win_vld) begin
			p_q[0] <= wcol_q[0]; p_q[1] <= wcol_q[1]; p_q[2] <= top_rd;
			p_q[3] <= wcol_q[2]; p_q[4] <= wcol_q[3]; p_q[5] <= mid_rd;
			p_q[6] <= wcol_q[4]; p_q[7] <= wcol_q[5]; p_q[8] <= pixel;
		end
	end

	// Select one coefficient per tap
	always_comb begin
		unique case (tap)
			4'd0, 4'd1, 4'd2: begin crow = coef_top; tk = 2'(tap); end
			4'd3, 4'd4, 4'd5: begin crow = coef_mid; tk = 2'(tap - 4'd3); end
			default: begin crow = coef_bot; tk = 2'(tap - 4'd6); end
		endcase
		cf = crow[tk*CB +: CB];
		prod = cf * $signed({2'b00, p_q[tap > 4'd8 ? 4'd8 : tap]});
	end

	// Accumulate the weighted sum one tap a cycle
	always_ff @(posedge clk) begin
		if (cmd.mac_clr) acc_q <= '0;
		else if (cmd.mac_step) acc_q <= acc_q + SW'(prod);
	end

	// Restoring division of the magnitude, one bit a cycle
	assign rem_sh = {rem_q, quo_q[SW-1]};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q <= acc_q[SW-1];
			quo_q <= acc_q[SW-1] ? SW'(-acc_q) : SW'(acc_q);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_sh >= {{(SW-7){1'b0}}, divisor}) begin
				rem_q <= SW'(rem_sh - {{(SW-7){1'b0}}, divisor});
				quo_q <= {quo_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= SW'(rem_sh);
				quo_q <= {quo_q[SW-2:0], 1'b0};
			end
		end
	end
	assign sts.div_need = divisor > 8'd1;

	// Restore sign and limit to one byte: wrap the signed result, saturate the magnitude, or clamp
	always_comb begin
		sval = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (out_mode == c3d_pkg::MODE_WRAP) res_pix <= sval[7:0];
			else if (out_mode == c3d_pkg::MODE_ABS)
				res_pix <= (quo_q > SW'(255)) ? 8'hFF : quo_q[7:0];
			else if (neg_q) res_pix <= 8'h00;
			else res_pix <= (quo_q > SW'(255)) ? 8'hFF : quo_q[7:0];
		end
	end
endmodule

// ----- hw/rtl/c3d_ctrl.sv -----
module c3d_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              hit,
	input  logic              out_busy,
	input  c3d_pkg::c3d_sts_t sts,
	output c3d_pkg::c3d_cmd_t cmd,
	output logic              idle,
	output logic              done,
	output logic [3:0]        tap
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_DIVS = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic hit_q;
	logic [4:0] cnt_q;

	assign tap = cnt_q[3:0];
	assign idle = state_q == ST_IDLE;

	// Issue commands per state
	always_comb begin
		cmd = '0;
		done = 1'b0;
		unique case (state_q)
			ST_READ: begin cmd.load = 1'b1; cmd.win_vld = hit_q; cmd.mac_clr = 1'b1; end
			ST_MAC: cmd.mac_step = 1'b1;
			ST_DIVS: cmd.div_start = 1'b1;
			ST_DIV: cmd.div_step = sts.div_need;
			ST_FIN: cmd.finish = 1'b1;
			ST_OUT: done = !out_busy;
			default: ;
		endcase
	end

	// Sequence one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; hit_q <= 1'b0; cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) begin state_q <= ST_READ; hit_q <= hit; end
				ST_READ: begin cnt_q <= '0; state_q <= hit_q ? ST_MAC : ST_IDLE; end
				ST_MAC: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) state_q <= ST_DIVS;
				end
				ST_DIVS: begin cnt_q <= '0; state_q <= ST_DIV; end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (!sts.div_need || cnt_q == 5'(c3d_pkg::DIV_STEPS - 1)) state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_OUT;
				ST_OUT: if (!out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/conv3x3_decimate_by_two.sv -----
// An item with no result passes through ST_IDLE and ST_READ; when a window closes, ST_READ is
// followed by ST_MAC (9 multiply-accumulate steps), ST_DIVS, ST_DIV (24 division steps when the
// divisor is above 1, else none), ST_FIN and ST_OUT before the result is in the output register.
// One item at a time: s_tready stays low until the item is through, and longer while an earlier
// result still waits in the output register.
// arst_n clears position, window and registers to their defaults; line stores are not cleared.
`include "conv3x3_decimate_by_two_assert.svh"
module conv3x3_decimate_by_two #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // pixel[7:0]
	input  logic        s_tuser,  // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_pixel[7:0], out_col[16:8], out_row[27:17], zeros
	output logic [1:0]  m_tuser,  // end_of_row[0], end_of_frame[1]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_wdata
);
	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CB = c3d_pkg::COEF_BITS;

	logic [3*CB-1:0] coef_top_q, coef_mid_q, coef_bot_q;
	logic [7:0] div_q;
	logic [1:0] mode_q;
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [CW-1:0] col_q, col_c, w_eff;
	logic [RW-1:0] row_q, row_c, h_eff;
	logic [7:0] pix_q;
	logic [AW-1:0] wr_addr_q;
	logic in_fire, hit, idle, done;
	logic [8:0] ocol_q;
	logic [10:0] orow_q;
	logic eor_q, eof_q;
	logic [7:0] res_pix;
	logic [3:0] tap;
	c3d_pkg::c3d_cmd_t cmd;
	c3d_pkg::c3d_sts_t sts;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_top_q <= '0; coef_mid_q <= '0; coef_bot_q <= '0;
			div_q <= '0; mode_q <= c3d_pkg::MODE_ABS; width_q <= 11'd1024; height_q <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				c3d_pkg::REG_COEF_TOP: coef_top_q <= cfg_wdata[3*CB-1:0];
				c3d_pkg::REG_COEF_MID: coef_mid_q <= cfg_wdata[3*CB-1:0];
				c3d_pkg::REG_COEF_BOT: coef_bot_q <= cfg_wdata[3*CB-1:0];
				c3d_pkg::REG_DIVISOR: div_q <= cfg_wdata[7:0];
				c3d_pkg::REG_OUT_MODE: mode_q <= cfg_wdata[1:0];
				c3d_pkg::REG_WIDTH: width_q <= cfg_wdata[10:0];
				c3d_pkg::REG_HEIGHT: height_q <= cfg_wdata[12:0];
				default: ;
			endcase
		end
	end

	// Clamp frame size
	always_comb begin
		if (width_q < 11'd3) w_eff = CW'(3);
		else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q < 13'd3) h_eff = RW'(3);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
		else h_eff = RW'(height_q);
	end

	assign s_tready = idle;
	assign in_fire = s_tvalid && s_tready;
	assign col_c = s_tuser ? '0 : col_q;
	assign row_c = s_tuser ? '0 : row_q;
	assign hit = col_c >= CW'(2) && row_c >= RW'(2) && !col_c[0] && !row_c[0]
		&& col_c < w_eff && row_c < h_eff;

	// Position and output tags on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0;
		end else if (in_fire) begin
			if (col_c + CW'(1) >= w_eff) begin
				col_q <= '0;
				row_q <= (row_c + RW'(1) >= h_eff) ? '0 : row_c + RW'(1);
			end else begin
				col_q <= col_c + CW'(1);
				row_q <= row_c;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= s_tdata;
			wr_addr_q <= AW'(col_c);
			ocol_q <= 9'((col_c - CW'(2)) >> 1);
			orow_q <= 11'((row_c - RW'(2)) >> 1);
			eor_q <= (CW+1)'(col_c) + (CW+1)'(2) >= (CW+1)'(w_eff);
			eof_q <= ((CW+1)'(col_c) + (CW+1)'(2) >= (CW+1)'(w_eff))
				&& ((RW+1)'(row_c) + (RW+1)'(2) >= (RW+1)'(h_eff));
		end
	end

	c3d_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .hit(hit),
		.out_busy(m_tvalid && !m_tready), .sts(sts), .cmd(cmd),
		.idle(idle), .done(done), .tap(tap));

	c3d_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .pixel(pix_q),
		.col_addr(idle ? AW'(col_c) : wr_addr_q), .tap(tap),
		.coef_top(coef_top_q), .coef_mid(coef_mid_q), .coef_bot(coef_bot_q),
		.divisor(div_q), .out_mode(mode_q), .res_pix(res_pix));

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (done) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata <= {4'd0, orow_q, ocol_q, res_pix};
			m_tuser <= {eof_q, eor_q};
		end
	end

	`C3D_ASSERT_IMPL(a_ready_idle, clk, arst_n, s_tready, !cmd.mac_step)
	`C3D_ASSERT_NEXT(a_done_valid, clk, arst_n, done, m_tvalid)
	`C3D_ASSERT_IMPL(a_eof_eor, clk, arst_n, m_tvalid, !m_tuser[1] || m_tuser[0])
endmodule

// ----- sim/tb.sv -----
`default_nettype none
module tb;
	typedef struct {
		logic [7:0] px;
		logic       fs;
	} pixel_item_t;

	typedef struct {
		logic [7:0]  px;
		logic [8:0]  col;
		logic [10:0] row;
		logic        eor;
		logic        eof;
	} conv_result_t;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = c3d_pkg::REG_COEF_TOP;
	logic [23:0] cfg_wdata = '0;

	pixel_item_t  pixel_queue[$];
	conv_result_t result_queue[$];
	int send_idle = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int cycles = 0;

	// predictor state and register copies
	logic [23:0] coef_rows[3];
	logic [7:0]  div_reg;
	logic [1:0]  mode_reg;
	logic [10:0] width_reg;
	logic [12:0] height_reg;
	logic [7:0]  older_line[MAX_W];
	logic [7:0]  newer_line[MAX_W];
	logic [7:0]  win_cols[6];
	int          col_pos;
	int          row_pos;

	conv3x3_decimate_by_two dut (.*);

	always #1 clk = ~clk;

	function automatic int eff_size(int v, int hi);
		return v < 3 ? 3 : (v > hi ? hi : v);
	endfunction

	// advance the window one pixel and queue the filtered result when a window closes
	function automatic void predict_pixel(logic [7:0] px, logic fs);
		int w, h, c, r, sum;
		logic [7:0] top, mid;
		logic [7:0] taps[9];
		conv_result_t res;
		w = eff_size(width_reg, MAX_W);
		h = eff_size(height_reg, MAX_H);
		top = '0;
		mid = '0;
		sum = 0;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		if (c < MAX_W) begin
			top = older_line[c];
			mid = newer_line[c];
			older_line[c] = mid;
			newer_line[c] = px;
		end
		if (c >= 2 && r >= 2 && c % 2 == 0 && r % 2 == 0 && c < w && r < h) begin
			taps = '{win_cols[0], win_cols[1], top, win_cols[2], win_cols[3], mid,
				win_cols[4], win_cols[5], px};
			for (int i = 0; i < 9; i++)
				sum += $signed(coef_rows[i / 3][(i % 3) * 8 +: 8]) * int'(taps[i]);
			if (div_reg > 1)
				sum = sum / int'(div_reg);
			if (mode_reg == c3d_pkg::MODE_WRAP) begin
				res.px = sum[7:0];
			end else begin
				if (sum < 0)
					sum = (mode_reg == c3d_pkg::MODE_ABS) ? -sum : 0;
				res.px = sum > 255 ? 8'd255 : sum[7:0];
			end
			res.col = 9'((c - 2) >> 1);
			res.row = 11'((r - 2) >> 1);
			res.eor = (c + 2 >= w);
			res.eof = res.eor && (r + 2 >= h);
			result_queue.push_back(res);
		end
		win_cols = '{win_cols[1], top, win_cols[3], mid, win_cols[5], px};
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = c;
		row_pos = r;
	endfunction

	// feed pixels from the pending queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_queue[0].px;
				s_tuser <= pixel_queue[0].fs;
				void'(pixel_queue.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// random back-pressure on the result side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall);
	end

	// predict on every input transfer, check every output transfer
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && s_tvalid && s_tready)
			predict_pixel(s_tdata, s_tuser);
		if (arst_n && m_tvalid && m_tready) begin
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h user %b", m_tdata, m_tuser);
			end else begin
				want = result_queue.pop_front();
				if (m_tdata[7:0] !== want.px || m_tdata[16:8] !== want.col ||
						m_tdata[27:17] !== want.row || m_tdata[31:28] !== 4'd0 ||
						m_tuser[0] !== want.eor || m_tuser[1] !== want.eof) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want px %0d col %0d row %0d eor %b eof %b, got %h user %b",
							want.px, want.col, want.row, want.eor, want.eof, m_tdata, m_tuser);
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			c3d_pkg::REG_COEF_TOP: coef_rows[0] = val;
			c3d_pkg::REG_COEF_MID: coef_rows[1] = val;
			c3d_pkg::REG_COEF_BOT: coef_rows[2] = val;
			c3d_pkg::REG_DIVISOR: div_reg = val[7:0];
			c3d_pkg::REG_OUT_MODE: mode_reg = val[1:0];
			c3d_pkg::REG_WIDTH: width_reg = val[10:0];
			c3d_pkg::REG_HEIGHT: height_reg = val[12:0];
			default: ;
		endcase
	endtask

	// hold until every pixel is taken and every result has arrived
	task automatic drain();
		wait (pixel_queue.size() == 0 && !s_tvalid && result_queue.size() == 0);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_window(logic [23:0] t, logic [23:0] m, logic [23:0] b,
			logic [7:0] dv, logic [1:0] md, logic [10:0] w, logic [12:0] h);
		write_reg(c3d_pkg::REG_COEF_TOP, t);
		write_reg(c3d_pkg::REG_COEF_MID, m);
		write_reg(c3d_pkg::REG_COEF_BOT, b);
		write_reg(c3d_pkg::REG_DIVISOR, 24'(dv));
		write_reg(c3d_pkg::REG_OUT_MODE, 24'(md));
		write_reg(c3d_pkg::REG_WIDTH, 24'(w));
		write_reg(c3d_pkg::REG_HEIGHT, 24'(h));
	endtask

	// queue n pixels starting a frame; noisy frames carry stray frame starts
	task automatic push_frame(int n, bit noisy, int fixed_px);
		pixel_item_t it;
		for (int i = 0; i < n; i++) begin
			it.px = fixed_px >= 0 ? 8'(fixed_px) : 8'($urandom_range(255));
			it.fs = (i == 0) || (noisy && $urandom_range(19) == 0);
			pixel_queue.push_back(it);
		end
	endtask

	initial begin
		int sent, w, h;
		coef_rows = '{24'd0, 24'd0, 24'd0};
		div_reg = 8'd0;
		mode_reg = c3d_pkg::MODE_ABS;
		width_reg = 11'd1024;
		height_reg = 13'd480;
		win_cols = '{default: 8'd0};
		col_pos = 0;
		row_pos = 0;
		for (int i = 0; i < MAX_W; i++) begin
			older_line[i] = 8'd0;
			newer_line[i] = 8'd0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme coefficients and pixels in every mode
		set_window(24'h808080, 24'h808080, 24'h808080, 8'd0, c3d_pkg::MODE_ABS,
			11'd3, 13'd3);
		push_frame(9, 0, 255);
		drain();
		set_window(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd1, c3d_pkg::MODE_WRAP,
			11'd0, 13'd0);
		push_frame(9, 0, 255);
		push_frame(9, 0, 0);
		drain();
		write_reg(c3d_pkg::REG_OUT_MODE, 24'(c3d_pkg::MODE_CLAMP));
		write_reg(c3d_pkg::REG_DIVISOR, 24'd255);
		push_frame(9, 0, 255);
		drain();
		write_reg(c3d_pkg::REG_OUT_MODE, 24'(c3d_pkg::MODE_SPARE));
		write_reg(c3d_pkg::REG_COEF_MID, 24'h80FF01);
		write_reg(c3d_pkg::REG_DIVISOR, 24'd7);
		push_frame(18, 0, -1);
		drain();
		// tallest frame register value
		set_window(24'hFF01FF, 24'h010801, 24'h7F0080, 8'd2, c3d_pkg::MODE_ABS,
			11'd4, 13'd8191);
		push_frame(24, 0, -1);
		drain();

		// random phases: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1) ? 53 : (ph == 3) ? 34 : 0;
			recv_stall = (ph == 2) ? 53 : (ph == 3) ? 34 : 0;
			sent = 0;
			while (sent < 270) begin
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 9);
				set_window(24'($urandom), 24'($urandom), 24'($urandom),
					8'($urandom_range(0, 9)), 2'($urandom_range(0, 3)), 11'(w), 13'(h));
				for (int f = 0; f < 2; f++) begin
					push_frame(w * h, $urandom_range(4) == 0, -1);
					sent += w * h;
				end
				drain();
			end
		end

		if (mismatches == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
